>>> design/ep5_pkg.sv
// ep5_pkg: binary32 constants and helper types for the exp_poly5_fp32 block.
// Uses no other file.
package ep5_pkg;
  localparam logic [31:0] INV_LN2_BITS = 32'h3FB8AA3B;
  localparam logic [31:0] LN2_BITS     = 32'h3F317218;
  localparam logic [31:0] C3_BITS      = 32'h3E2AAAAB;
  localparam logic [31:0] C4_BITS      = 32'h3D2AAAAB;
  localparam logic [31:0] C5_BITS      = 32'h3C088889;
  localparam logic [31:0] HALF_BITS    = 32'h3F000000;
  localparam logic [31:0] ONE_BITS     = 32'h3F800000;
  localparam logic [31:0] NAN_BITS     = 32'h7FC00000;
  localparam logic [31:0] EXP_BIAS     = 32'd127;
  localparam int          MANT_BITS    = 23;

  // Operands of a multiply-add; c is unused by a plain multiply.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } fma_op_t;
endpackage

>>> design/ep5_if.sv
// ep5_if: valid/ready channel carrying a 32-bit binary32 word and a last flag.
// Uses no other file.
interface ep5_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  logic        last;
  modport source (output valid, output data, output last, input ready);
  modport sink (input valid, input data, input last, output ready);
endinterface

>>> design/ep5_fma.sv
// ep5_fma: pipelined binary32 fused multiply-add, one result per cycle when enabled.
// Uses ep5_pkg (fma_op_t, NAN_BITS, MANT_BITS). Three register stages: product, align/add, round.
module ep5_fma
  import ep5_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic        use_c,
  input  fma_op_t     op,
  output logic [31:0] res
);
  // stage 1: unpack and 24x24 product
  logic        sa, sb, sc;
  logic [7:0]  ea, eb, ec;
  logic [23:0] ma, mb, mc;
  logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;

  always_comb begin
    // plain multiply adds -0, which keeps the product's zero sign
    sa = op.a[31]; sb = op.b[31]; sc = use_c ? op.c[31] : 1'b1;
    ea = op.a[30:23]; eb = op.b[30:23]; ec = use_c ? op.c[30:23] : 8'd0;
    ma = {(ea != 8'd0), op.a[22:0]};
    mb = {(eb != 8'd0), op.b[22:0]};
    mc = use_c ? {(ec != 8'd0), op.c[22:0]} : 24'd0;
    a_nan = (ea == 8'hFF) && (op.a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (op.b[22:0] != 23'd0);
    c_nan = (ec == 8'hFF) && (mc[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (op.a[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (op.b[22:0] == 23'd0);
    c_inf = (ec == 8'hFF) && (mc[22:0] == 23'd0);
    a_zero = (ea == 8'd0) && (op.a[22:0] == 23'd0);
    b_zero = (eb == 8'd0) && (op.b[22:0] == 23'd0);
    c_zero = (ec == 8'd0) && (mc[22:0] == 23'd0);
  end

  logic [47:0] prod_r;
  logic signed [10:0] pexp_r, cexp_r;
  logic [23:0] mc_r;
  logic        ps_r, cs_r, cz_r, pz_r, nan1_r, inf1_r, infs1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= ma * mb;
      // product value = prod * 2^(pexp - 173); subnormals use exponent 1
      pexp_r  <= $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
               + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd127;
      cexp_r  <= $signed({3'd0, (ec == 8'd0) ? 8'd1 : ec});
      mc_r    <= mc;
      ps_r    <= sa ^ sb;
      cs_r    <= sc;
      cz_r    <= c_zero;
      pz_r    <= a_zero | b_zero;
      nan1_r  <= a_nan | b_nan | c_nan | (a_inf & b_zero) | (b_inf & a_zero)
               | ((a_inf | b_inf) & c_inf & ((sa ^ sb) != sc));
      inf1_r  <= a_inf | b_inf | c_inf;
      infs1_r <= (a_inf | b_inf) ? (sa ^ sb) : sc;
    end
  end

  // stage 2: align on a wide fixed window and add; sticky collected below it
  // window: 76 bits, value = w * 2^(emax - 201), emax the larger exponent term
  logic signed [10:0] pe, ce, emax, dp, dc;
  logic [75:0] pw, cw;
  logic        pst, cst;
  logic [76:0] sum;
  logic        ssign;

  always_comb begin
    pe = pexp_r;           // product placed at bits 75:28 of the window
    ce = cexp_r - 11'sd1;  // addend placed at bits 75:52, same scale
    emax = (pz_r || (!cz_r && ce > pe)) ? ce : pe;
    dp = emax - pe;
    dc = emax - ce;
    pw = 76'd0; cw = 76'd0; pst = 1'b0; cst = 1'b0;
    if (!pz_r) begin
      if (dp > 11'sd75) pst = 1'b1;
      else begin
        pw  = ({prod_r, 28'd0}) >> dp;
        pst = ((({prod_r, 28'd0}) & ((76'd1 << dp) - 76'd1)) != 76'd0);
      end
    end
    if (!cz_r) begin
      if (dc > 11'sd75) cst = 1'b1;
      else begin
        cw  = ({mc_r, 52'd0}) >> dc;
        cst = ((({mc_r, 52'd0}) & ((76'd1 << dc) - 76'd1)) != 76'd0);
      end
    end
    // only one side can carry a sticky tail; treat it as a fraction below lsb
    if (ps_r == cs_r) begin
      sum = {1'b0, pw} + {1'b0, cw};
      ssign = ps_r;
    end else if ({pw, pst} >= {cw, cst}) begin
      sum = {1'b0, pw} - {1'b0, cw} - {76'd0, cst & ~pst};
      ssign = ps_r;
    end else begin
      sum = {1'b0, cw} - {1'b0, pw} - {76'd0, pst & ~cst};
      ssign = cs_r;
    end
  end

  logic [76:0] sum_r;
  logic        st2_r, sg2_r, nan2_r, inf2_r, infs2_r, zz2_r, zs2_r;
  logic signed [10:0] emax_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum;
      st2_r   <= pst | cst;
      sg2_r   <= ssign;
      emax_r  <= emax;
      nan2_r  <= nan1_r;
      inf2_r  <= inf1_r;
      infs2_r <= infs1_r;
      zz2_r   <= pz_r & cz_r;
      zs2_r   <= ps_r & cs_r;
    end
  end

  // stage 3: normalize and round to nearest even
  logic [6:0]  lz;
  logic [76:0] nrm;
  logic signed [12:0] be, sh;
  logic [23:0] q;
  logic [25:0] qq;
  logic        g, stk;
  logic [52:0] tail;
  logic [31:0] out;

  always_comb begin
    lz = 7'd77;
    for (int i = 0; i < 77; i++) if (sum_r[i]) lz = 7'(76 - i);
    // msb at bit 76 has weight 2^(emax-125), biased exponent emax+2
    be = 13'(emax_r) + 13'sd2 - $signed({6'd0, lz});
    sh = 13'sd0;
    if (be < 13'sd1) sh = 13'sd1 - be;
    nrm = sum_r << lz;
    if (sh > 13'sd60) begin
      nrm = 77'd0;
      stk = (sum_r != 77'd0) | st2_r;
    end else begin
      stk = ((nrm & ((77'd1 << sh) - 77'd1)) != 77'd0) | st2_r;
      nrm = nrm >> sh;
    end
    q    = nrm[76:53];
    g    = nrm[52];
    tail = {1'b0, nrm[51:0]};
    stk  = stk | (tail != 53'd0);
    qq   = {2'b0, q} + {25'd0, g & (stk | q[0])};
    if (be < 13'sd1) begin
      out = {sg2_r, 31'(qq)};
    end else begin
      // hidden bit of qq carries the exponent from be-1 up to be
      out = {sg2_r, (31'(be - 13'sd1) << MANT_BITS) + {5'd0, qq}};
      if (be >= 13'sd255 || {1'b0, out[30:0]} >= 32'h7F800000
          || (be == 13'sd254 && qq[24]))
        out = {sg2_r, 31'h7F800000};
    end
    if (sum_r == 77'd0 && !st2_r) out = {zz2_r ? zs2_r : 1'b0, 31'd0};
    if (inf2_r) out = {infs2_r, 31'h7F800000};
    if (nan2_r) out = NAN_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) res <= out;
  end
endmodule

>>> design/exp_poly5_fp32.sv
// exp_poly5_fp32: top level of the pipelined binary32 exp approximation.
// Uses ep5_pkg, ep5_if and ep5_fma.
//
// Approximate exp(x) for a binary32 argument: n = rne(x/ln2), r = x - n*ln2
// (fused), Horner degree-5 polynomial p(r) by five fused multiply-adds, then
// y = p * 2^n with 2^n built as ((int32(n)+127)<<23), wrapping with no range
// check. The block accepts one transfer per cycle when not stalled and returns
// one result per input in order, through eight chained 3-stage FP units plus
// the register after the integer rounding of n. The whole pipe advances only
// when its output register is empty or being taken, so a stall holds every
// stage and loses nothing. Overflow, underflow and the 2^n wrap are not
// special-cased; any NaN result comes out as 0x7FC00000.
module exp_poly5_fp32
  import ep5_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  ep5_if.sink   in_ch,
  ep5_if.source out_ch
);
  localparam int NU  = 8;   // FP units in the chain
  localparam int LAT = 3;   // register stages in each unit
  localparam int DEP = NU * LAT + 1;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // valid and side data shift line over the whole depth
  logic [DEP-1:0] vld_r;
  logic [31:0]    xd_r [DEP];
  logic [31:0]    nd_r [DEP];
  logic [31:0]    rd_r [DEP];
  logic           ld_r [DEP];

  logic [31:0] u_res [NU];
  fma_op_t     u_op  [NU];
  logic        u_c   [NU];

  // n = rne(x*inv_ln2): integer rounding at stage after unit 0
  function automatic logic [31:0] rint(input logic [31:0] b);
    logic [7:0]  ex;
    logic [23:0] sig, q;
    logic [4:0]  sh;
    logic [23:0] rem, half;
    logic [24:0] qq;
    logic [5:0]  lz;
    logic [31:0] o;
    begin
      ex = b[30:23];
      sig = {1'b1, b[22:0]};
      o = {b[31], 31'd0};
      if (ex >= 8'd150) o = b;
      else if (ex >= 8'd126) begin
        sh = 5'(150 - ex);
        q = sig >> sh;
        rem = sig & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 5'd1);
        qq = {1'b0, q} + {24'd0, (rem > half) || (rem == half && q[0])};
        lz = 6'd0;
        for (int i = 0; i < 25; i++) if (qq[i]) lz = 6'(i);
        if (qq == 25'd0) o = {b[31], 31'd0};
        else o = {b[31], 8'(8'd127 + 8'(lz)), 23'((qq << (6'd23 - lz)) & 25'h7FFFFF)};
      end
      rint = o;
    end
  endfunction

  function automatic logic [31:0] toint(input logic [31:0] b);
    logic [7:0]  ex;
    logic [54:0] sg;
    logic [31:0] mag;
    begin
      ex = b[30:23];
      sg = {31'd0, 1'b1, b[22:0]};
      if (ex == 8'hFF && b[22:0] != 23'd0) toint = 32'd0;
      else if (ex >= 8'd158) toint = b[31] ? 32'h80000000 : 32'h7FFFFFFF;
      else if (ex < 8'd127) toint = 32'd0;
      else begin
        mag = (ex >= 8'd150) ? 32'(sg << (ex - 8'd150)) : 32'(sg >> (8'd150 - ex));
        toint = b[31] ? (32'd0 - mag) : mag;
      end
    end
  endfunction

  logic [31:0] n_val, two_n;
  assign n_val = rint(u_res[0]);
  assign two_n = (toint(nd_r[2*LAT]) + EXP_BIAS) << MANT_BITS;

  always_comb begin
    u_op[0] = '{a: in_ch.data, b: INV_LN2_BITS, c: 32'd0};  u_c[0] = 1'b0;
    u_op[1] = '{a: nd_r[LAT] ^ 32'h80000000, b: LN2_BITS, c: xd_r[LAT]};
    u_c[1] = 1'b1;
    u_op[2] = '{a: C5_BITS, b: u_res[1], c: C4_BITS};        u_c[2] = 1'b1;
    u_op[3] = '{a: u_res[2], b: rd_r[3*LAT], c: C3_BITS};    u_c[3] = 1'b1;
    u_op[4] = '{a: u_res[3], b: rd_r[4*LAT], c: HALF_BITS};  u_c[4] = 1'b1;
    u_op[5] = '{a: u_res[4], b: rd_r[5*LAT], c: ONE_BITS};   u_c[5] = 1'b1;
    u_op[6] = '{a: u_res[5], b: rd_r[6*LAT], c: ONE_BITS};   u_c[6] = 1'b1;
    u_op[7] = '{a: u_res[6], b: nd_r[7*LAT], c: 32'd0};      u_c[7] = 1'b0;
  end

  for (genvar k = 0; k < NU; k++) begin : g_u
    ep5_fma u_fma (.clk(clk), .en(en), .use_c(u_c[k]), .op(u_op[k]), .res(u_res[k]));
  end

  // side data: x, n (then 2^n), r delayed alongside the units
  always_ff @(posedge clk) begin
    if (en) begin
      xd_r[0] <= in_ch.data;
      ld_r[0] <= in_ch.last;
      nd_r[0] <= 32'd0;
      rd_r[0] <= 32'd0;
      for (int i = 1; i < DEP; i++) begin
        xd_r[i] <= xd_r[i-1];
        ld_r[i] <= ld_r[i-1];
        // n loads as unit 0 retires, then is replaced by the 2^n pattern
        nd_r[i] <= (i == LAT) ? n_val : ((i == 2*LAT+1) ? two_n : nd_r[i-1]);
        // r loads as unit 1 retires
        rd_r[i] <= (i == 2*LAT+1) ? u_res[1] : rd_r[i-1];
      end
    end
  end

  // realign: units read side data at their entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEP-2:0], in_ch.valid};
  end

  // last unit's result register is the output register
  assign out_ch.valid = vld_r[DEP-1];
  assign out_ch.data  = u_res[NU-1];
  assign out_ch.last  = ld_r[DEP-1];
endmodule
